[hdl/jinl_pkg.sv]
`timescale 1ns / 1ps

package jinl_pkg;

    // Field widths of the beats and the register.
    localparam int BYTE_W   = 8;
    localparam int REASON_W = 3;
    localparam int MAXB_W   = 16;
    localparam int TOTAL_W  = 17;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register map, as word indexes.
    localparam logic [0:0] REG_MAX_BYTES = 1'b0;

    // Reset value of max_bytes.
    localparam logic [MAXB_W-1:0] MAX_BYTES_RESET = 16'd8192;

    // Verdict codes.
    localparam logic [REASON_W-1:0] REASON_OK        = 3'd0;
    localparam logic [REASON_W-1:0] REASON_TOO_LONG  = 3'd1;
    localparam logic [REASON_W-1:0] REASON_NUL       = 3'd2;
    localparam logic [REASON_W-1:0] REASON_BAD_NUM   = 3'd3;
    localparam logic [REASON_W-1:0] REASON_OPEN_STR  = 3'd4;

    // Characters the scanner looks for.
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_LOWER_E   = 8'h65;
    localparam logic [BYTE_W-1:0] CH_UPPER_E   = 8'h45;
    localparam logic [BYTE_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;

endpackage

[hdl/jinl_if.sv]
`timescale 1ns / 1ps

// Channel that carries document bytes into the block.
interface jinl_byte_if
    import jinl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_doc;

    modport source (output valid, output text_byte, output end_of_doc, input ready);
    modport sink   (input valid, input text_byte, input end_of_doc, output ready);
endinterface

// Channel that carries one verdict per document out of the block.
interface jinl_verdict_if
    import jinl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                accepted;
    logic [REASON_W-1:0] reject_reason;

    modport source (output valid, output accepted, output reject_reason, input ready);
    modport sink   (input valid, input accepted, input reject_reason, output ready);
endinterface

[hdl/json_integer_number_lint_unit.sv]
`timescale 1ns / 1ps

// JSON integer-number syntax checker.
// i_byte_ch carries the document one byte per beat; end_of_doc marks the
// final byte. o_verdict_ch carries one beat per document: accepted, and a
// reject_reason of ok, too long, NUL byte, bad number or unterminated string.
// The APB port holds max_bytes at address 0; write it only while idle.
// Throughput is one byte per cycle while no final byte waits: the scan state is
// updated by a single level of logic from the input register.
// The final byte's beat passes through the input register and then the
// verdict register before it leaves as the verdict beat.
// When the receiver stalls, the verdict register holds its beat and the
// input register keeps taking non-final bytes; a final byte waits in the
// input register until the verdict register is free, and i_byte_ch.ready
// is low only while such a final byte waits.
// A synchronous reset empties both registers, clears all scan state and
// sets max_bytes back to 8192.
module json_integer_number_lint_unit
    import jinl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    jinl_byte_if.sink         i_byte_ch,
    jinl_verdict_if.source    o_verdict_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration register.
    logic [MAXB_W-1:0] r_max_bytes;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_BYTES);
    assign prdata = (paddr[2] == REG_MAX_BYTES) ?
                    {{(APB_DW-MAXB_W){1'b0}}, r_max_bytes} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (cfg_wr) begin
            r_max_bytes <= pwdata[MAXB_W-1:0];
        end
    end

    // Input register and verdict register with their handshakes.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    logic              r_out_accepted;
    logic [REASON_W-1:0] r_out_reason;
    logic              scan_adv;
    logic              in_take;

    assign scan_adv = r_in_valid && (!r_in_last || !r_out_valid || o_verdict_ch.ready);
    assign i_byte_ch.ready = !r_in_valid || scan_adv;
    assign in_take = i_byte_ch.valid && i_byte_ch.ready;

    assign o_verdict_ch.valid         = r_out_valid;
    assign o_verdict_ch.accepted      = r_out_accepted;
    assign o_verdict_ch.reject_reason = r_out_reason;

    // Scan state.
    logic               r_in_str, n_in_str;
    logic               r_esc, n_esc;
    logic               r_in_num, n_in_num;
    logic [1:0]         r_digits, n_digits;
    logic               r_lead_zero, n_lead_zero;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_nul, n_nul;
    logic               r_num_fault, n_num_fault;
    logic [REASON_W-1:0] n_reason;

    // One byte's state update, then the verdict on a final byte.
    always_comb begin
        logic c_digit;
        logic rescan;
        c_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
        rescan  = 1'b1;

        n_in_str    = r_in_str;
        n_esc       = r_esc;
        n_in_num    = r_in_num;
        n_digits    = r_digits;
        n_lead_zero = r_lead_zero;
        n_num_fault = r_num_fault;
        n_total     = (r_total == {TOTAL_W{1'b1}}) ? r_total : r_total + 1'b1;
        n_nul       = r_nul || (r_in_byte == CH_NUL);
        n_reason    = REASON_OK;

        // An open number either takes a digit or ends on this byte.
        if (r_in_num) begin
            if (c_digit) begin
                rescan = 1'b0;
                if (r_digits == 2'd0) begin
                    n_lead_zero = (r_in_byte == CH_ZERO);
                end
                if (r_digits != 2'd2) begin
                    n_digits = r_digits + 2'd1;
                end
            end else begin
                if ((r_digits == 2'd0) || ((r_digits == 2'd2) && r_lead_zero) ||
                    (r_in_byte == CH_DOT) || (r_in_byte == CH_LOWER_E) ||
                    (r_in_byte == CH_UPPER_E)) begin
                    n_num_fault = 1'b1;
                end
                n_in_num    = 1'b0;
                n_digits    = 2'd0;
                n_lead_zero = 1'b0;
            end
        end

        // The byte as an ordinary token, also the byte that closed a number.
        if (rescan) begin
            if (r_in_str) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (r_in_byte == CH_BACKSLASH) begin
                    n_esc = 1'b1;
                end else if (r_in_byte == CH_QUOTE) begin
                    n_in_str = 1'b0;
                end
            end else if (r_in_byte == CH_QUOTE) begin
                n_in_str = 1'b1;
            end else if ((r_in_byte == CH_MINUS) || c_digit) begin
                n_in_num    = 1'b1;
                n_digits    = c_digit ? 2'd1 : 2'd0;
                n_lead_zero = (r_in_byte == CH_ZERO);
            end
        end

        // A number still open at the end is checked without a follower.
        if (n_in_num && ((n_digits == 2'd0) || ((n_digits == 2'd2) && n_lead_zero))) begin
            if (r_in_last) begin
                n_num_fault = 1'b1;
            end
        end

        if (n_total > {1'b0, r_max_bytes}) begin
            n_reason = REASON_TOO_LONG;
        end else if (n_nul) begin
            n_reason = REASON_NUL;
        end else if (n_num_fault) begin
            n_reason = REASON_BAD_NUM;
        end else if (n_in_str || n_esc) begin
            n_reason = REASON_OPEN_STR;
        end
    end

    // Control registers of the two stages and the scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_str    <= 1'b0;
            r_esc       <= 1'b0;
            r_in_num    <= 1'b0;
            r_digits    <= 2'd0;
            r_lead_zero <= 1'b0;
            r_total     <= '0;
            r_nul       <= 1'b0;
            r_num_fault <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (scan_adv) begin
                r_in_valid <= 1'b0;
            end

            if (scan_adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_verdict_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            if (scan_adv) begin
                if (r_in_last) begin
                    r_in_str    <= 1'b0;
                    r_esc       <= 1'b0;
                    r_in_num    <= 1'b0;
                    r_digits    <= 2'd0;
                    r_lead_zero <= 1'b0;
                    r_total     <= '0;
                    r_nul       <= 1'b0;
                    r_num_fault <= 1'b0;
                end else begin
                    r_in_str    <= n_in_str;
                    r_esc       <= n_esc;
                    r_in_num    <= n_in_num;
                    r_digits    <= n_digits;
                    r_lead_zero <= n_lead_zero;
                    r_total     <= n_total;
                    r_nul       <= n_nul;
                    r_num_fault <= n_num_fault;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_ch.text_byte;
            r_in_last <= i_byte_ch.end_of_doc;
        end
        if (scan_adv && r_in_last) begin
            r_out_accepted <= (n_reason == REASON_OK);
            r_out_reason   <= n_reason;
        end
    end

endmodule

[hdl/jinl_checker.sv]
`timescale 1ns / 1ps

// Port-level checks of the lint unit.
module jinl_checker
    import jinl_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_out_accepted,
    input logic [REASON_W-1:0] i_out_reason,
    input logic                i_psel,
    input logic                i_penable,
    input logic                i_pwrite,
    input logic [APB_AW-1:0]   i_paddr,
    input logic [APB_DW-1:0]   i_pwdata,
    input logic [APB_DW-1:0]   i_prdata
);

    // A stalled verdict beat keeps its payload.
    a_verdict_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_reason)
        && $stable(i_out_accepted))
        else $error("verdict beat changed while stalled");

    // The accept flag agrees with the reason code.
    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_accepted == (i_out_reason == REASON_OK)))
        else $error("accepted disagrees with reject_reason");

    // Only the defined reason codes appear.
    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_reason <= REASON_OPEN_STR))
        else $error("reject_reason out of range");

    // Reset empties the verdict register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("verdict beat present after reset");

    // A write of max_bytes reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr == '0)
        |=> (i_paddr != '0) || (i_prdata[MAXB_W-1:0] == $past(i_pwdata[MAXB_W-1:0])))
        else $error("max_bytes does not read back");

endmodule

bind json_integer_number_lint_unit jinl_checker u_jinl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_verdict_ch.valid),
    .i_out_ready    (o_verdict_ch.ready),
    .i_out_accepted (o_verdict_ch.accepted),
    .i_out_reason   (o_verdict_ch.reject_reason),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);

[bench/jinl_verdict_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps a scan model of the
// document in flight, and compares every verdict beat with the oldest
// predicted verdict.
module jinl_verdict_checker
    import jinl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    jinl_byte_if              i_byte_ch,
    jinl_verdict_if           i_verdict_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic                accepted;
        logic [REASON_W-1:0] reason;
    } t_verdict;

    localparam logic [APB_AW-1:0] MAX_BYTES_ADDR = APB_AW'({REG_MAX_BYTES, 2'b00});

    // Scan state of the document being received.
    logic                str_open;
    logic                escape_open;
    logic                in_number;
    logic [1:0]          digit_seen;
    logic                zero_first;
    logic [TOTAL_W-1:0]  doc_length;
    logic                nul_seen;
    logic                number_broken;
    logic [MAXB_W-1:0]   length_limit;

    t_verdict            expected_verdicts[$];
    int                  error_total;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void take_digit(input logic [BYTE_W-1:0] c);
        if (digit_seen == 2'd0) begin
            zero_first = (c == CH_ZERO);
        end
        if (digit_seen < 2'd2) begin
            digit_seen = digit_seen + 2'd1;
        end
    endfunction

    // A number is malformed with no digits, or with several digits led by zero.
    function automatic logic number_malformed();
        return digit_seen == 2'd0 || (digit_seen > 2'd1 && zero_first);
    endfunction

    function automatic void clear_document();
        str_open      = 1'b0;
        escape_open   = 1'b0;
        in_number     = 1'b0;
        digit_seen    = 2'd0;
        zero_first    = 1'b0;
        doc_length    = '0;
        nul_seen      = 1'b0;
        number_broken = 1'b0;
    endfunction

    // Advances the scan by one byte; returns 1 with the verdict on a final byte.
    function automatic logic scan_byte(input logic [BYTE_W-1:0] c, input logic last,
                                       output t_verdict verdict);
        logic                rescan;
        logic [REASON_W-1:0] reason;
        verdict = '0;
        if (doc_length != '1) begin
            doc_length = doc_length + 1'b1;
        end
        if (c == CH_NUL) begin
            nul_seen = 1'b1;
        end

        // An open number either takes the digit or closes here.
        rescan = 1'b1;
        if (in_number) begin
            if (is_digit(c)) begin
                take_digit(c);
                rescan = 1'b0;
            end else begin
                if (number_malformed() || c == CH_DOT || c == CH_LOWER_E ||
                    c == CH_UPPER_E) begin
                    number_broken = 1'b1;
                end
                in_number  = 1'b0;
                digit_seen = 2'd0;
                zero_first = 1'b0;
            end
        end

        // The byte that closed a number is scanned again as an ordinary byte.
        if (rescan) begin
            if (str_open) begin
                if (escape_open) begin
                    escape_open = 1'b0;
                end else if (c == CH_BACKSLASH) begin
                    escape_open = 1'b1;
                end else if (c == CH_QUOTE) begin
                    str_open = 1'b0;
                end
            end else if (c == CH_QUOTE) begin
                str_open = 1'b1;
            end else if (c == CH_MINUS || is_digit(c)) begin
                in_number  = 1'b1;
                digit_seen = 2'd0;
                zero_first = 1'b0;
                if (is_digit(c)) begin
                    take_digit(c);
                end
            end
        end

        if (!last) begin
            return 1'b0;
        end

        // A number still open at the end gets its own check.
        if (in_number && number_malformed()) begin
            number_broken = 1'b1;
        end

        if (doc_length > {1'b0, length_limit}) begin
            reason = REASON_TOO_LONG;
        end else if (nul_seen) begin
            reason = REASON_NUL;
        end else if (number_broken) begin
            reason = REASON_BAD_NUM;
        end else if (str_open || escape_open) begin
            reason = REASON_OPEN_STR;
        end else begin
            reason = REASON_OK;
        end
        verdict.accepted = (reason == REASON_OK);
        verdict.reason   = reason;
        clear_document();
        return 1'b1;
    endfunction

    // Sample every beat at the clock edge; verdicts are matched before new
    // bytes are scanned so a verdict can never pair with its own final byte.
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict fresh;
        if (!i_rst_n) begin
            clear_document();
            length_limit = MAX_BYTES_RESET;
            expected_verdicts.delete();
            error_total = 0;
        end else begin
            if (i_verdict_ch.valid && i_verdict_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    error_total = error_total + 1;
                    $display("%0t: verdict beat with none expected: accepted %0d reason %0d",
                             $time, i_verdict_ch.accepted, i_verdict_ch.reject_reason);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_verdict_ch.accepted !== want.accepted) begin
                        error_total = error_total + 1;
                        $display("%0t: accepted mismatch: expected %0d actual %0d",
                                 $time, want.accepted, i_verdict_ch.accepted);
                    end
                    if (i_verdict_ch.reject_reason !== want.reason) begin
                        error_total = error_total + 1;
                        $display("%0t: reject_reason mismatch: expected %0d actual %0d",
                                 $time, want.reason, i_verdict_ch.reject_reason);
                    end
                end
            end
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                if (scan_byte(i_byte_ch.text_byte, i_byte_ch.end_of_doc, fresh)) begin
                    expected_verdicts.push_back(fresh);
                end
            end
            if (psel && penable && pwrite && pready && paddr == MAX_BYTES_ADDR) begin
                length_limit = pwdata[MAXB_W-1:0];
            end
        end
        o_errors  <= error_total;
        o_pending <= expected_verdicts.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import jinl_pkg::*;

    typedef logic [BYTE_W-1:0] t_text;
    typedef t_text t_text_q[$];

    localparam logic [APB_AW-1:0] MAX_BYTES_ADDR = APB_AW'({REG_MAX_BYTES, 2'b00});
    localparam int LONG_HOLD_CYCLES = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                error_count;
    int                verdicts_due;
    int                burst_left = 0;
    logic              hold_request = 1'b0;

    jinl_byte_if    byte_ch ();
    jinl_verdict_if verdict_ch ();

    json_integer_number_lint_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .o_verdict_ch (verdict_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    jinl_verdict_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .i_verdict_ch (verdict_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_errors     (error_count),
        .o_pending    (verdicts_due)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Receiver: open stretches, random stalls, short blocks, and one long
    // hold-off that lets the block back up onto its input.
    initial begin
        verdict_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                verdict_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            case ($urandom_range(0, 2))
                0: begin
                    verdict_ch.ready <= 1'b1;
                    repeat ($urandom_range(10, 120)) @(posedge i_clk);
                end
                1: begin
                    repeat ($urandom_range(20, 80)) begin
                        verdict_ch.ready <= ($urandom_range(0, 99) < 55);
                        @(posedge i_clk);
                    end
                end
                default: begin
                    verdict_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            endcase
        end
    end

    function automatic t_text pick_delimiter();
        string marks;
        marks = " ,]}:\n";
        return t_text'(marks[$urandom_range(0, marks.len() - 1)]);
    endfunction

    // Appends one lexical piece: mostly well-formed JSON, some malformed
    // numbers, and some noise.
    task automatic add_token(ref t_text doc[$]);
        int    pick;
        string punct;
        pick  = $urandom_range(0, 99);
        punct = "{}[],: \t\ntrue";
        if (pick < 25) begin
            // Well-formed integer, sometimes left open at the end.
            if ($urandom_range(0, 2) == 0) begin
                doc.push_back(CH_MINUS);
            end
            if ($urandom_range(0, 3) == 0) begin
                doc.push_back(CH_ZERO);
            end else begin
                doc.push_back(t_text'($urandom_range(CH_ZERO + 1, CH_NINE)));
                repeat ($urandom_range(0, 3)) begin
                    doc.push_back(t_text'($urandom_range(CH_ZERO, CH_NINE)));
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                doc.push_back(pick_delimiter());
            end
        end else if (pick < 37) begin
            // Malformed number.
            case ($urandom_range(0, 3))
                0: begin
                    doc.push_back(CH_MINUS);
                    doc.push_back(pick_delimiter());
                end
                1: begin
                    doc.push_back(CH_ZERO);
                    repeat ($urandom_range(1, 2)) begin
                        doc.push_back(t_text'($urandom_range(CH_ZERO, CH_NINE)));
                    end
                end
                2: begin
                    doc.push_back(t_text'($urandom_range(CH_ZERO, CH_NINE)));
                    case ($urandom_range(0, 2))
                        0: doc.push_back(CH_DOT);
                        1: doc.push_back(CH_LOWER_E);
                        default: doc.push_back(CH_UPPER_E);
                    endcase
                    doc.push_back(t_text'($urandom_range(CH_ZERO, CH_NINE)));
                end
                default: begin
                    doc.push_back(CH_MINUS);
                    doc.push_back(CH_QUOTE);
                end
            endcase
        end else if (pick < 62) begin
            // String with random content and escapes, usually closed.
            doc.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 4) == 0) begin
                    doc.push_back(CH_BACKSLASH);
                    doc.push_back(t_text'($urandom_range(1, 255)));
                end else begin
                    doc.push_back(t_text'($urandom_range(32, 126)));
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                doc.push_back(CH_QUOTE);
            end
        end else if (pick < 85) begin
            doc.push_back(t_text'(punct[$urandom_range(0, punct.len() - 1)]));
        end else if (pick < 96) begin
            doc.push_back(t_text'($urandom_range(1, 255)));
        end else if ($urandom_range(0, 1) == 0) begin
            doc.push_back(CH_NUL);
        end else begin
            doc.push_back(t_text'($urandom_range(0, 255)));
        end
    endtask

    // Blank document of a given length, closed by a lone zero digit.
    function automatic t_text_q blank_document(input int length);
        t_text_q doc;
        repeat (length - 1) doc.push_back(t_text'(" "));
        doc.push_back(CH_ZERO);
        return doc;
    endfunction

    // One byte beat; the sender runs in bursts with random gaps between them.
    task automatic send_beat(input t_text value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        byte_ch.valid      <= 1'b1;
        byte_ch.text_byte  <= value;
        byte_ch.end_of_doc <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic send_document(input t_text doc[$]);
        foreach (doc[i]) begin
            send_beat(doc[i], i == doc.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        t_text doc[$];
        for (int i = 0; i < s.len(); i++) begin
            doc.push_back(t_text'(s[i]));
        end
        send_document(doc);
    endtask

    task automatic send_random_documents(input int byte_budget);
        int    sent;
        t_text doc[$];
        sent = 0;
        while (sent < byte_budget) begin
            doc.delete();
            repeat ($urandom_range(1, 5)) add_token(doc);
            send_document(doc);
            sent = sent + doc.size();
        end
    endtask

    // Lets every verdict drain and the pipeline empty before the next phase.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (verdicts_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_bytes(input logic [MAXB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_BYTES_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        byte_ch.valid      <= 1'b0;
        byte_ch.text_byte  <= '0;
        byte_ch.end_of_doc <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases at the reset limit: plain zero, negative zero, lone sign,
        // leading zero, fraction and exponents, open string, open escape, escaped
        // quote, number closed by a quote, NUL and a high byte.
        send_text("0");
        send_text("-0");
        send_text("-");
        send_text("01");
        send_text("1.");
        send_text("1e");
        send_text("7E");
        send_text("\"a");
        send_text("\"\\");
        send_text("\"\\\"\"");
        send_text("9\"");
        send_document('{CH_NUL});
        send_document('{t_text'(8'hFF)});
        settle();

        // Length boundary at a small limit.
        write_max_bytes(16'd24);
        send_document(blank_document(24));
        send_document(blank_document(25));
        settle();

        // A limit of one and its boundary, then zero.
        write_max_bytes(16'd1);
        send_document(blank_document(1));
        send_document(blank_document(2));
        send_random_documents(100);
        settle();
        write_max_bytes(16'd0);
        send_random_documents(40);
        settle();

        // Largest limit.
        write_max_bytes(16'hFFFF);
        send_random_documents(100);
        settle();

        // Small random limit; the receiver holds off for a long stretch.
        write_max_bytes(MAXB_W'($urandom_range(2, 40)));
        hold_request = 1'b1;
        send_random_documents(860);
        settle();

        write_max_bytes(MAX_BYTES_RESET);
        send_random_documents(160);
        settle();

        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
